### sv/tcm_access_router_core_defines.svh
// Assertion macros shared by the router RTL
`ifndef TCM_ACCESS_ROUTER_CORE_DEFINES_SVH
`define TCM_ACCESS_ROUTER_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define TCMAR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante
`define TCMAR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/tcmar_pkg.sv
package tcmar_pkg;

   // Default store sizes in bytes (powers of two)
   localparam int ITCM_BYTES_DEF = 32768;
   localparam int DTCM_BYTES_DEF = 16384;

   // Byte lanes per memory row
   localparam int LANES = 4;

   // Port widths
   localparam int REQ_DATA_W = 72;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 104;
   localparam int RSP_USER_W = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 32;

   // Access kinds
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_FETCH = 2'd2;

   // Access sizes
   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;
   localparam logic [1:0] SIZE_WORD = 2'd2;

   // Target of an access
   localparam logic [1:0] SERVED_ITCM = 2'd0;
   localparam logic [1:0] SERVED_DTCM = 2'd1;
   localparam logic [1:0] SERVED_EXT  = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_ITCM_BASE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ITCM_END  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ITCM_MASK = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_DTCM_BASE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_DTCM_END  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_DTCM_MASK = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_CONTROL   = 3'd6;

   // Control register bits
   localparam int CTL_ITCM_EN = 0;
   localparam int CTL_ITCM_LD = 1;
   localparam int CTL_DTCM_EN = 2;
   localparam int CTL_DTCM_LD = 3;

   // Register reset values
   localparam logic [14:0] ITCM_MASK_RST = 15'h7FFF;
   localparam logic [13:0] DTCM_MASK_RST = 14'h3FFF;

   // Lane strobe of one store access
   typedef struct packed {
      logic [LANES-1:0] en;
      logic             we;
   } lane_ctl_type;

   // Bytes of an access that carry data, lowest byte first
   function automatic logic [LANES-1:0] size_keep(input logic [1:0] sc);
      logic [LANES-1:0] keep;
      case (sc)
         SIZE_BYTE: keep = 4'b0001;
         SIZE_HALF: keep = 4'b0011;
         default:   keep = 4'b1111;
      endcase
      return keep;
   endfunction

endpackage

### sv/tcm_access_router_core.sv
// Channel  | Direction | Handshake             | Payload
// req      | in        | req_tvalid/req_tready | tdata: access, tuser: op, is_code
// rsp      | out       | rsp_tvalid/rsp_tready | tdata: result fields, tuser: served_by
// csr      | in        | csr_valid/csr_ready   | csr_index, csr_data
//
// An accepted word passes the input register, the registered read of the byte-lane
// memories and the output register on its way to rsp; one word a cycle is sustained
// while rsp does not stall.
// After reset both stores are zeroed, one row of four bytes a cycle; req_tready stays
// low until both clearing passes are done. csr is always ready.
// A stall on rsp holds the pipeline back stage by stage; req_tready also drops when it is full.
`include "tcm_access_router_core_defines.svh"

module tcm_access_router_core #(
   parameter int ITCM_BYTES = tcmar_pkg::ITCM_BYTES_DEF,
   parameter int DTCM_BYTES = tcmar_pkg::DTCM_BYTES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [31:0] address, [33:32] size_code, [34] side_effect, [66:35] write_data, rest zero
   input  logic [tcmar_pkg::REQ_DATA_W-1:0]      req_tdata,
   // [1:0] op, [2] is_code
   input  logic [tcmar_pkg::REQ_USER_W-1:0]      req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [31:0] read_data, [63:32] aligned_address, [64] ext_write, [96:65] ext_write_data,
   // [98:97] ext_size_code, [99] ext_side_effect, rest zero
   output logic [tcmar_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // [1:0] served_by
   output logic [tcmar_pkg::RSP_USER_W-1:0]      rsp_tuser,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tcmar_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tcmar_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int I_ROWS  = ITCM_BYTES / tcmar_pkg::LANES;
   localparam int D_ROWS  = DTCM_BYTES / tcmar_pkg::LANES;
   localparam int I_ROW_W = $clog2(I_ROWS);
   localparam int D_ROW_W = $clog2(D_ROWS);
   localparam int I_OFF_W = $clog2(ITCM_BYTES);
   localparam int D_OFF_W = $clog2(DTCM_BYTES);

   // Configuration registers
   logic [31:0] itcm_base_ff;
   logic [31:0] itcm_end_ff;
   logic [14:0] itcm_mask_ff;
   logic [31:0] dtcm_base_ff;
   logic [31:0] dtcm_end_ff;
   logic [13:0] dtcm_mask_ff;
   logic [3:0]  control_ff;

   assign csr_ready = 1'b1;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         itcm_base_ff <= '0;
         itcm_end_ff  <= '0;
         itcm_mask_ff <= tcmar_pkg::ITCM_MASK_RST;
         dtcm_base_ff <= '0;
         dtcm_end_ff  <= '0;
         dtcm_mask_ff <= tcmar_pkg::DTCM_MASK_RST;
         control_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            tcmar_pkg::REG_ITCM_BASE: itcm_base_ff <= csr_data;
            tcmar_pkg::REG_ITCM_END:  itcm_end_ff  <= csr_data;
            tcmar_pkg::REG_ITCM_MASK: itcm_mask_ff <= csr_data[14:0];
            tcmar_pkg::REG_DTCM_BASE: dtcm_base_ff <= csr_data;
            tcmar_pkg::REG_DTCM_END:  dtcm_end_ff  <= csr_data;
            tcmar_pkg::REG_DTCM_MASK: dtcm_mask_ff <= csr_data[13:0];
            tcmar_pkg::REG_CONTROL:   control_ff   <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // Pipeline flow control
   logic a_vld_ff, a_vld_in;
   logic b_vld_ff, b_vld_in;
   logic rsp_vld_ff, rsp_vld_in;
   logic out_free, b_free, a_free;
   logic a_adv, b_adv, req_acc;
   logic i_ready, d_ready;

   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign b_adv      = b_vld_ff && out_free;
   assign b_free     = !b_vld_ff || out_free;
   assign a_adv      = a_vld_ff && b_free;
   assign a_free     = !a_vld_ff || b_free;
   assign req_tready = a_free && i_ready && d_ready;
   assign req_acc    = req_tvalid && req_tready;

   assign a_vld_in   = req_acc ? 1'b1 : (a_adv ? 1'b0 : a_vld_ff);
   assign b_vld_in   = a_adv ? 1'b1 : (b_adv ? 1'b0 : b_vld_ff);
   assign rsp_vld_in = b_adv ? 1'b1 : (rsp_tready ? 1'b0 : rsp_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff   <= 1'b0;
         b_vld_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         a_vld_ff   <= a_vld_in;
         b_vld_ff   <= b_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Stage A: input register
   logic [1:0]  a_op_ff;
   logic [31:0] a_addr_ff;
   logic [1:0]  a_sc_ff;
   logic        a_code_ff;
   logic        a_side_ff;
   logic [31:0] a_wdata_ff;

   always_ff @(posedge clock) begin
      if (req_acc) begin
         a_op_ff    <= req_tuser[1:0];
         a_code_ff  <= req_tuser[2];
         a_addr_ff  <= req_tdata[31:0];
         a_sc_ff    <= req_tdata[33:32];
         a_side_ff  <= req_tdata[34];
         a_wdata_ff <= req_tdata[66:35];
      end
   end

   // Stage A: align, route and work out lane addresses
   logic        a_write, a_fetch;
   logic [1:0]  a_sc;
   logic [31:0] a_aligned;
   logic        to_i, to_d;
   logic [1:0]  a_served;
   logic [31:0] i_diff, d_diff, i_off32, d_off32;
   logic [I_OFF_W-1:0] i_off;
   logic [D_OFF_W-1:0] d_off;
   logic [3:0]  a_keep;
   logic [1:0]  a_rot;

   always_comb begin
      a_write = (a_op_ff == tcmar_pkg::OP_WRITE);
      a_fetch = (a_op_ff == tcmar_pkg::OP_FETCH);
      a_sc    = (a_sc_ff == 2'd3) ? tcmar_pkg::SIZE_WORD : a_sc_ff;
      case (a_sc)
         tcmar_pkg::SIZE_BYTE: a_aligned = a_addr_ff;
         tcmar_pkg::SIZE_HALF: a_aligned = {a_addr_ff[31:1], 1'b0};
         default:              a_aligned = {a_addr_ff[31:2], 2'b00};
      endcase
      a_keep = tcmar_pkg::size_keep(a_sc);

      to_i = (a_aligned >= itcm_base_ff) && (a_aligned < itcm_end_ff)
           && control_ff[tcmar_pkg::CTL_ITCM_EN]
           && (a_write || !control_ff[tcmar_pkg::CTL_ITCM_LD]);
      to_d = !to_i && !a_fetch && !a_code_ff
           && (a_aligned >= dtcm_base_ff) && (a_aligned < dtcm_end_ff)
           && control_ff[tcmar_pkg::CTL_DTCM_EN]
           && (a_write || !control_ff[tcmar_pkg::CTL_DTCM_LD]);
      a_served = to_i ? tcmar_pkg::SERVED_ITCM
               : (to_d ? tcmar_pkg::SERVED_DTCM : tcmar_pkg::SERVED_EXT);

      i_diff  = a_aligned - itcm_base_ff;
      d_diff  = a_aligned - dtcm_base_ff;
      i_off32 = i_diff & {17'd0, itcm_mask_ff};
      d_off32 = a_write ? (d_diff & {18'd0, dtcm_mask_ff}) : d_diff;
      i_off   = i_off32[I_OFF_W-1:0];
      d_off   = d_off32[D_OFF_W-1:0];
      a_rot   = to_i ? i_off[1:0] : d_off[1:0];
   end

   // Spread the access over the byte lanes of each store
   tcmar_pkg::lane_ctl_type                         i_ctl, d_ctl;
   logic [tcmar_pkg::LANES-1:0][I_ROW_W-1:0]        i_row;
   logic [tcmar_pkg::LANES-1:0][D_ROW_W-1:0]        d_row;
   logic [tcmar_pkg::LANES-1:0][7:0]                i_wbyte, d_wbyte;
   logic [tcmar_pkg::LANES-1:0][7:0]                i_rbyte, d_rbyte;
   logic [1:0]                                      i_idx, d_idx;

   always_comb begin
      i_idx = '0;
      d_idx = '0;
      for (int b = 0; b < tcmar_pkg::LANES; b++) begin
         i_idx        = 2'(b) - i_off[1:0];
         d_idx        = 2'(b) - d_off[1:0];
         i_ctl.en[b]  = a_keep[i_idx] && to_i && a_adv;
         d_ctl.en[b]  = a_keep[d_idx] && to_d && a_adv;
         i_row[b]     = i_off[I_OFF_W-1:2] + I_ROW_W'(2'(b) < i_off[1:0]);
         d_row[b]     = d_off[D_OFF_W-1:2] + D_ROW_W'(2'(b) < d_off[1:0]);
         i_wbyte[b]   = a_wdata_ff[i_idx*8 +: 8];
         d_wbyte[b]   = a_wdata_ff[d_idx*8 +: 8];
      end
      i_ctl.we = a_write;
      d_ctl.we = a_write;
   end

   tcmar_store #(.ROWS(I_ROWS)) u_itcm (
      .clock (clock),
      .reset (reset),
      .ctl   (i_ctl),
      .row   (i_row),
      .wdata (i_wbyte),
      .rdata (i_rbyte),
      .ready (i_ready)
   );

   tcmar_store #(.ROWS(D_ROWS)) u_dtcm (
      .clock (clock),
      .reset (reset),
      .ctl   (d_ctl),
      .row   (d_row),
      .wdata (d_wbyte),
      .rdata (d_rbyte),
      .ready (d_ready)
   );

   // Stage B: hold routing while the store read completes
   logic [1:0]  b_served_ff;
   logic [31:0] b_aligned_ff;
   logic        b_rd_ff;
   logic [1:0]  b_rot_ff;
   logic [3:0]  b_keep_ff;
   logic        b_ext_write_ff;
   logic [31:0] b_ext_wdata_ff;
   logic [1:0]  b_ext_sc_ff;
   logic        b_ext_side_ff;

   always_ff @(posedge clock) begin
      if (a_adv) begin
         b_served_ff    <= a_served;
         b_aligned_ff   <= a_aligned;
         b_rd_ff        <= (to_i || to_d) && !a_write;
         b_rot_ff       <= a_rot;
         b_keep_ff      <= a_keep;
         b_ext_write_ff <= !(to_i || to_d) && a_write;
         b_ext_wdata_ff <= (!(to_i || to_d) && a_write) ? a_wdata_ff : 32'd0;
         b_ext_sc_ff    <= (to_i || to_d) ? 2'd0 : a_sc;
         b_ext_side_ff  <= !(to_i || to_d) && !a_write && !a_fetch && a_side_ff;
      end
   end

   // Gather the read bytes back into access order
   logic [tcmar_pkg::LANES-1:0][7:0] sel_lane;
   logic [31:0]                      b_rdata;
   logic [1:0]                       r_idx;

   always_comb begin
      sel_lane = (b_served_ff == tcmar_pkg::SERVED_ITCM) ? i_rbyte : d_rbyte;
      r_idx    = '0;
      b_rdata  = '0;
      for (int i = 0; i < tcmar_pkg::LANES; i++) begin
         r_idx = b_rot_ff + 2'(i);
         b_rdata[i*8 +: 8] = (b_rd_ff && b_keep_ff[i]) ? sel_lane[r_idx] : 8'd0;
      end
   end

   // Output register
   logic [tcmar_pkg::RSP_DATA_W-1:0] rsp_tdata_ff;
   logic [tcmar_pkg::RSP_USER_W-1:0] rsp_tuser_ff;

   always_ff @(posedge clock) begin
      if (b_adv) begin
         rsp_tdata_ff <= {4'd0, b_ext_side_ff, b_ext_sc_ff, b_ext_wdata_ff,
                          b_ext_write_ff, b_aligned_ff, b_rdata};
         rsp_tuser_ff <= b_served_ff;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   `TCMAR_ASSERT_NOW(a_one_store, 1'b1, !((|i_ctl.en) && (|d_ctl.en)), "access sent to both stores")
   `TCMAR_ASSERT_NEXT(a_b_fill, a_adv, b_vld_ff, "stage B lost an advancing word")
   `TCMAR_ASSERT_NOW(a_tcm_ext_zero, rsp_tvalid && rsp_tuser != tcmar_pkg::SERVED_EXT, rsp_tdata[99:64] == 36'd0, "external fields set on a store access")
   `TCMAR_ASSERT_NEXT(a_ext_no_rdata, b_adv && b_served_ff == tcmar_pkg::SERVED_EXT, rsp_tdata[31:0] == 32'd0, "read data on an external request")

endmodule

### sv/tcmar_store.sv
`include "tcm_access_router_core_defines.svh"

module tcmar_store #(
   parameter int ROWS = tcmar_pkg::ITCM_BYTES_DEF / tcmar_pkg::LANES
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  tcmar_pkg::lane_ctl_type                  ctl,
   input  logic [tcmar_pkg::LANES-1:0][$clog2(ROWS)-1:0] row,
   input  logic [tcmar_pkg::LANES-1:0][7:0]         wdata,
   output logic [tcmar_pkg::LANES-1:0][7:0]         rdata,
   output logic                                     ready
);

   localparam int ROW_W = $clog2(ROWS);

   logic             clr_busy_ff;
   logic             clr_busy_in;
   logic [ROW_W-1:0] clr_row_ff;
   logic [ROW_W-1:0] clr_row_in;

   // Sweep every row once after reset, writing zeros
   always_comb begin
      clr_row_in  = clr_row_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_row_in = clr_row_ff + ROW_W'(1);
         if (clr_row_ff == ROW_W'(ROWS - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_row_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_row_ff  <= clr_row_in;
      end
   end

   assign ready = !clr_busy_ff;

   // One byte-wide memory per lane, one port each
   for (genvar g = 0; g < tcmar_pkg::LANES; g++) begin : g_lane
      logic [7:0] mem_ff [ROWS];
      logic [7:0] rd_ff;

      always_ff @(posedge clock) begin
         if (clr_busy_ff) begin
            mem_ff[clr_row_ff] <= 8'd0;
         end else if (ctl.en[g]) begin
            if (ctl.we) begin
               mem_ff[row[g]] <= wdata[g];
            end else begin
               rd_ff <= mem_ff[row[g]];
            end
         end
      end

      assign rdata[g] = rd_ff;
   end

   `TCMAR_ASSERT_NOW(a_no_access_in_clear, clr_busy_ff, ctl.en == 4'd0, "store accessed during clearing pass")
   `TCMAR_ASSERT_NEXT(a_clear_ends, clr_busy_ff && clr_row_ff == ROW_W'(ROWS - 1), !clr_busy_ff, "clearing pass did not end")

endmodule
